FILE: design/c32_pkg.sv
`timescale 1ns / 1ps

package c32_pkg;

    localparam int unsigned NUM_CHARS   = 6;
    localparam int unsigned SYM_W       = 5;
    localparam int unsigned VALUE_W     = NUM_CHARS * SYM_W;   // 30
    localparam int unsigned NUM_DIGITS  = 9;
    localparam int unsigned BCD_W       = NUM_DIGITS * 4;      // 36
    localparam int unsigned BITS_PER_ST = 6;                   // dabble steps per stage
    localparam int unsigned NUM_DAB_ST  = VALUE_W / BITS_PER_ST;
    localparam int unsigned SUM_W       = 7;                   // check sum fits in 0..72

    localparam logic [VALUE_W-1:0] MAX_VALUE = VALUE_W'(999999999);

    // Conversion word carried down the pipeline
    typedef struct packed {
        logic               ok;
        logic [VALUE_W-1:0] value;
        logic [VALUE_W-1:0] rem;    // bits still to shift into the BCD word, MSB first
        logic [BCD_W-1:0]   bcd;
    } t_conv;

    // Final result word
    typedef struct packed {
        logic               valid_res;
        logic [VALUE_W-1:0] number_value;
        logic [BCD_W-1:0]   digits_bcd;
        logic               check_ok;
    } t_result;

    // Symbol lookup: {in_alphabet, value}; alphabet has no A, E, I or O
    function automatic logic [SYM_W:0] sym_lookup(input logic [7:0] ch);
        logic [SYM_W:0] r;
        r = '0;
        unique case (ch)
            "0": r = {1'b1, 5'd0};
            "1": r = {1'b1, 5'd1};
            "2": r = {1'b1, 5'd2};
            "3": r = {1'b1, 5'd3};
            "4": r = {1'b1, 5'd4};
            "5": r = {1'b1, 5'd5};
            "6": r = {1'b1, 5'd6};
            "7": r = {1'b1, 5'd7};
            "8": r = {1'b1, 5'd8};
            "9": r = {1'b1, 5'd9};
            "B": r = {1'b1, 5'd10};
            "C": r = {1'b1, 5'd11};
            "D": r = {1'b1, 5'd12};
            "F": r = {1'b1, 5'd13};
            "G": r = {1'b1, 5'd14};
            "H": r = {1'b1, 5'd15};
            "J": r = {1'b1, 5'd16};
            "K": r = {1'b1, 5'd17};
            "L": r = {1'b1, 5'd18};
            "M": r = {1'b1, 5'd19};
            "N": r = {1'b1, 5'd20};
            "P": r = {1'b1, 5'd21};
            "Q": r = {1'b1, 5'd22};
            "R": r = {1'b1, 5'd23};
            "S": r = {1'b1, 5'd24};
            "T": r = {1'b1, 5'd25};
            "U": r = {1'b1, 5'd26};
            "V": r = {1'b1, 5'd27};
            "W": r = {1'b1, 5'd28};
            "X": r = {1'b1, 5'd29};
            "Y": r = {1'b1, 5'd30};
            "Z": r = {1'b1, 5'd31};
            default: r = '0;
        endcase
        return r;
    endfunction

    // One double-dabble step: add 3 to nibbles >= 5, then shift in one bit
    function automatic logic [BCD_W-1:0] dabble_step(input logic [BCD_W-1:0] bcd,
                                                     input logic            bit_in);
        logic [BCD_W-1:0] t;
        t = bcd;
        for (int n = 0; n < NUM_DIGITS; n++) begin
            if (t[n*4 +: 4] >= 4'd5) begin
                t[n*4 +: 4] = t[n*4 +: 4] + 4'd3;
            end
        end
        return {t[BCD_W-2:0], bit_in};
    endfunction

    // Odd-position digit: doubled, folded back below 10
    function automatic logic [3:0] dbl_fold(input logic [3:0] d);
        logic [4:0] t;
        t = {d, 1'b0};
        if (t > 5'd9) begin
            t = t - 5'd9;
        end
        return t[3:0];
    endfunction

    // Sum (0..72) mod 10: take off 40, then 20, then 10 where they fit
    function automatic logic [3:0] mod10(input logic [SUM_W-1:0] s);
        logic [SUM_W-1:0] t;
        t = s;
        if (t >= SUM_W'(40)) begin
            t = t - SUM_W'(40);
        end
        if (t >= SUM_W'(20)) begin
            t = t - SUM_W'(20);
        end
        if (t >= SUM_W'(10)) begin
            t = t - SUM_W'(10);
        end
        return t[3:0];
    endfunction

endpackage

FILE: design/c32_char_map.sv
`timescale 1ns / 1ps

module c32_char_map (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_valid,
    output logic                   o_ready,
    input  logic [7:0]             i_char0,
    input  logic [7:0]             i_char1,
    input  logic [7:0]             i_char2,
    input  logic [7:0]             i_char3,
    input  logic [7:0]             i_char4,
    input  logic [7:0]             i_char5,
    output logic                   o_valid,
    input  logic                   i_ready,
    output c32_pkg::t_conv         o_data
);
    import c32_pkg::*;

    logic [SYM_W:0]   s0, s1, s2, s3, s4, s5;
    logic [VALUE_W-1:0] value;
    t_conv            n_data;
    t_conv            r_data;
    logic             r_valid;

    // symbol lookup and base-32 assembly (pure concatenation)
    always_comb begin
        s0 = sym_lookup(i_char0);
        s1 = sym_lookup(i_char1);
        s2 = sym_lookup(i_char2);
        s3 = sym_lookup(i_char3);
        s4 = sym_lookup(i_char4);
        s5 = sym_lookup(i_char5);
        value = {s0[SYM_W-1:0], s1[SYM_W-1:0], s2[SYM_W-1:0],
                 s3[SYM_W-1:0], s4[SYM_W-1:0], s5[SYM_W-1:0]};
        n_data.ok    = s0[SYM_W] & s1[SYM_W] & s2[SYM_W] & s3[SYM_W] & s4[SYM_W]
                     & s5[SYM_W] & (value <= MAX_VALUE);
        n_data.value = value;
        n_data.rem   = value;
        n_data.bcd   = '0;
    end

    assign o_ready = !r_valid || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_data <= n_data;
        end
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;

endmodule

FILE: design/c32_dabble_stage.sv
`timescale 1ns / 1ps

module c32_dabble_stage (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    output logic           o_ready,
    input  c32_pkg::t_conv i_data,
    output logic           o_valid,
    input  logic           i_ready,
    output c32_pkg::t_conv o_data
);
    import c32_pkg::*;

    t_conv n_data;
    t_conv r_data;
    logic  r_valid;

    // a slice of the binary-to-BCD conversion, MSB first
    always_comb begin
        n_data = i_data;
        for (int k = 0; k < BITS_PER_ST; k++) begin
            n_data.bcd = dabble_step(n_data.bcd, n_data.rem[VALUE_W-1]);
            n_data.rem = {n_data.rem[VALUE_W-2:0], 1'b0};
        end
    end

    assign o_ready = !r_valid || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_data <= n_data;
        end
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;

endmodule

FILE: design/c32_check.sv
`timescale 1ns / 1ps

module c32_check (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    output logic             o_ready,
    input  c32_pkg::t_conv   i_data,
    output logic             o_valid,
    input  logic             i_ready,
    output c32_pkg::t_result o_data
);
    import c32_pkg::*;

    logic [3:0]       dig [NUM_DIGITS];
    logic [SUM_W-1:0] sum;
    t_result          n_data;
    t_result          r_data;
    logic             r_valid;

    // weighted digit sum; digit 0 sits in the top nibble
    always_comb begin
        for (int n = 0; n < NUM_DIGITS; n++) begin
            dig[n] = i_data.bcd[BCD_W-4-n*4 +: 4];
        end
        sum = SUM_W'(dig[0]) + SUM_W'(dbl_fold(dig[1]))
            + SUM_W'(dig[2]) + SUM_W'(dbl_fold(dig[3]))
            + SUM_W'(dig[4]) + SUM_W'(dbl_fold(dig[5]))
            + SUM_W'(dig[6]) + SUM_W'(dbl_fold(dig[7]));
    end

    // zero the result fields of a rejected code
    always_comb begin
        n_data.valid_res    = i_data.ok;
        n_data.number_value = i_data.ok ? i_data.value : '0;
        n_data.digits_bcd   = i_data.ok ? i_data.bcd : '0;
        n_data.check_ok     = i_data.ok && (mod10(sum) == dig[NUM_DIGITS-1]);
    end

    assign o_ready = !r_valid || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_data <= n_data;
        end
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;

endmodule

FILE: design/code32_payload_decoder.sv
`timescale 1ns / 1ps

// Code 32 payload decoder: takes the six ASCII data characters of a symbol and
// returns the nine-digit number as binary and packed BCD, a valid flag (all
// characters in the alphabet without A, E, I and O, and value <= 999999999) and
// the mod-10 check result. Fully pipelined: one transaction per cycle while the
// output is not stalled, through symbol lookup, five double-dabble stages of six
// bits each and the check digit stage. Each stage holds one transaction; a stall
// on the output fills empty stages first, so input is still taken while bubbles
// remain. Rejected codes give zero in all result fields.
module code32_payload_decoder (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [7:0]  i_char0,
    input  logic [7:0]  i_char1,
    input  logic [7:0]  i_char2,
    input  logic [7:0]  i_char3,
    input  logic [7:0]  i_char4,
    input  logic [7:0]  i_char5,
    output logic        o_valid,
    input  logic        i_stall,
    output logic        o_valid_res,
    output logic [29:0] o_number_value,
    output logic [35:0] o_digits_bcd,
    output logic        o_check_ok
);
    import c32_pkg::*;

    logic    st_valid [NUM_DAB_ST+1];
    logic    st_ready [NUM_DAB_ST+1];
    t_conv   st_data  [NUM_DAB_ST+1];
    logic    map_ready;
    logic    chk_valid;
    logic    chk_ready;
    t_result chk_data;

    // symbol lookup
    c32_char_map u_map (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (map_ready),
        .i_char0 (i_char0),
        .i_char1 (i_char1),
        .i_char2 (i_char2),
        .i_char3 (i_char3),
        .i_char4 (i_char4),
        .i_char5 (i_char5),
        .o_valid (st_valid[0]),
        .i_ready (st_ready[0]),
        .o_data  (st_data[0])
    );

    // binary to BCD
    for (genvar g = 0; g < NUM_DAB_ST; g++) begin : g_dab
        c32_dabble_stage u_dab (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_valid (st_valid[g]),
            .o_ready (st_ready[g]),
            .i_data  (st_data[g]),
            .o_valid (st_valid[g+1]),
            .i_ready (st_ready[g+1]),
            .o_data  (st_data[g+1])
        );
    end

    // check digit and output register
    c32_check u_chk (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (st_valid[NUM_DAB_ST]),
        .o_ready (st_ready[NUM_DAB_ST]),
        .i_data  (st_data[NUM_DAB_ST]),
        .o_valid (chk_valid),
        .i_ready (chk_ready),
        .o_data  (chk_data)
    );

    assign chk_ready      = !i_stall;
    assign o_stall        = !map_ready;
    assign o_valid        = chk_valid;
    assign o_valid_res    = chk_data.valid_res;
    assign o_number_value = chk_data.number_value;
    assign o_digits_bcd   = chk_data.digits_bcd;
    assign o_check_ok     = chk_data.check_ok;

    // rejected code carries all-zero result fields
    a_reject_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_valid_res |-> o_number_value == '0 && o_digits_bcd == '0
                                    && !o_check_ok)
        else $error("rejected code with nonzero result");

    // accepted value stays within nine decimal digits
    a_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_valid_res |-> o_number_value <= 30'd999999999)
        else $error("valid result out of range");

    // every BCD digit of an accepted code is decimal
    a_bcd_digits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_valid_res |->
            o_digits_bcd[35:32] <= 4'd9 && o_digits_bcd[31:28] <= 4'd9 &&
            o_digits_bcd[27:24] <= 4'd9 && o_digits_bcd[23:20] <= 4'd9 &&
            o_digits_bcd[19:16] <= 4'd9 && o_digits_bcd[15:12] <= 4'd9 &&
            o_digits_bcd[11:8]  <= 4'd9 && o_digits_bcd[7:4]   <= 4'd9 &&
            o_digits_bcd[3:0]   <= 4'd9)
        else $error("non-decimal BCD digit");

    // an empty output stage means the pipe can always take input
    a_no_stall_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_valid |-> !o_stall)
        else $error("input stalled with empty output stage");

endmodule
